@@ rtl/m6502am_pkg.sv @@
`default_nettype none

package m6502am_pkg;

  localparam int AddrWidth = 16;
  localparam int ByteWidth = 8;
  localparam int MemDepth  = 1 << AddrWidth;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  typedef enum logic [3:0] {
    MODE_ACC  = 4'd0,
    MODE_IMM  = 4'd1,
    MODE_ABS  = 4'd2,
    MODE_ABSX = 4'd3,
    MODE_ABSY = 4'd4,
    MODE_ZPX  = 4'd5,
    MODE_ZPY  = 4'd6,
    MODE_IND  = 4'd7,
    MODE_INDX = 4'd8,
    MODE_INDY = 4'd9,
    MODE_REL  = 4'd10,
    MODE_IMP  = 4'd11,
    MODE_ZP   = 4'd12
  } mode_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  mode;
    logic [15:0] prog_counter;
    logic [7:0]  x_index;
    logic [7:0]  y_index;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] effective_address;
    logic [15:0] next_pc;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP0,
    ST_OP1,
    ST_OP2,
    ST_PT0,
    ST_PT1,
    ST_PT2,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_PC,
    RD_PC1,
    RD_PTR,
    RD_PTR1
  } rd_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    mem_wr;
    logic    mem_rd;
    rd_sel_t rd_sel;
    logic    cap_b0;
    logic    cap_b1;
    logic    cap_p0;
    logic    cap_p1;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
  } status_t;

  // operand bytes that follow the opcode
  function automatic logic [1:0] op_bytes(logic [3:0] mode);
    logic [1:0] n;
    case (mode_t'(mode))
      MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: n = 2'd2;
      MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY,
      MODE_INDX, MODE_INDY, MODE_REL:           n = 2'd1;
      default:                                  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic uses_ptr(logic [3:0] mode);
    logic u;
    case (mode_t'(mode))
      MODE_IND, MODE_INDX, MODE_INDY: u = 1'b1;
      default:                        u = 1'b0;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mos6502_address_mode_unit.sv @@
// 6502 effective-address unit with its own 64 KiB byte memory behind one
// single-port RAM with registered read. A write beat stores one byte and
// returns nothing. A resolve beat returns one result beat with the effective
// address and the advanced program counter. A resolve goes straight to the
// finish state for accumulator, implied and unused mode codes; it reads one
// operand byte for immediate, zero-page and relative modes (immediate still
// steps through the operand fetch states), two for absolute modes, one plus
// two pointer bytes for (zp,X) and (zp),Y and two of each for indirect. A
// finished result sits in an output register, so the next beat is taken
// while it waits; a new result is held back only while the previous one is
// still stalled. Memory contents are undefined until written.
`default_nettype none

module mos6502_address_mode_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire m6502am_pkg::in_item_t   in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output m6502am_pkg::out_item_t       out_data
);
  import m6502am_pkg::*;

  cmd_t    cmd;
  status_t status;

  m6502am_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_mode   (in_data.mode),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  m6502am_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/m6502am_ram.sv @@
`default_nettype none

module m6502am_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/m6502am_ctrl.sv @@
`default_nettype none

module m6502am_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_kind,
  input  wire logic [3:0]            in_mode,
  input  wire logic                  out_stall,
  input  wire m6502am_pkg::status_t  status,
  output logic                       in_stall,
  output logic                       out_valid,
  output m6502am_pkg::cmd_t          cmd
);
  import m6502am_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_RESOLVE) begin
          state_nxt = (op_bytes(in_mode) == 2'd0) ? ST_FIN : ST_OP0;
        end
      end
      ST_OP0: state_nxt = ST_OP1;
      ST_OP1: begin
        if (op_bytes(status.mode) == 2'd2) begin
          state_nxt = ST_OP2;
        end else if (uses_ptr(status.mode)) begin
          state_nxt = ST_PT0;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_OP2: state_nxt = uses_ptr(status.mode) ? ST_PT0 : ST_FIN;
      ST_PT0: state_nxt = ST_PT1;
      ST_PT1: state_nxt = ST_PT2;
      ST_PT2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (!out_vld_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid && in_kind == KIND_RESOLVE;
        cmd.mem_wr    = in_valid && in_kind == KIND_WRITE;
      end
      ST_OP0: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_PC;
      end
      ST_OP1: begin
        cmd.cap_b0 = 1'b1;
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_PC1;
      end
      ST_OP2: cmd.cap_b1 = 1'b1;
      ST_PT0: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_PTR;
      end
      ST_PT1: begin
        cmd.cap_p0 = 1'b1;
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_PTR1;
      end
      ST_PT2: cmd.cap_p1 = 1'b1;
      ST_FIN: cmd.load_out = !out_vld_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  assign out_vld_nxt = cmd.load_out || (out_vld_r && out_stall);
  assign out_valid   = out_vld_r;

endmodule

`default_nettype wire

@@ rtl/m6502am_dp.sv @@
`default_nettype none

module m6502am_dp (
  input  wire logic                   clk,
  input  wire m6502am_pkg::in_item_t  in_data,
  input  wire m6502am_pkg::cmd_t      cmd,
  output m6502am_pkg::status_t        status,
  output m6502am_pkg::out_item_t      out_data
);
  import m6502am_pkg::*;

  logic [3:0]           mode_r;
  logic [15:0]          pc_r;
  logic [7:0]           x_r;
  logic [7:0]           y_r;
  logic [7:0]           b0_r;
  logic [7:0]           b1_r;
  logic [7:0]           p0_r;
  logic [7:0]           p1_r;
  out_item_t            out_r;

  logic [AddrWidth-1:0] mem_addr;
  logic [ByteWidth-1:0] mem_rdata;
  logic [7:0]           ptr_lo;
  logic [7:0]           ptr_hi;
  logic [15:0]          base;
  logic [15:0]          ea_nxt;
  logic [15:0]          npc_nxt;

  m6502am_ram #(
    .Width (ByteWidth),
    .Depth (MemDepth)
  ) u_mem (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .re    (cmd.mem_rd),
    .addr  (mem_addr),
    .wdata (in_data.write_data),
    .rdata (mem_rdata)
  );

  // pointer: zero page for (zp,X) and (zp),Y, page wrap on the high byte fetch
  assign ptr_lo = (mode_t'(mode_r) == MODE_INDX) ? b0_r + x_r : b0_r;
  assign ptr_hi = (mode_t'(mode_r) == MODE_IND) ? b1_r : 8'h00;

  always_comb begin
    if (cmd.mem_wr) begin
      mem_addr = in_data.write_addr;
    end else begin
      case (cmd.rd_sel)
        RD_PC:   mem_addr = pc_r;
        RD_PC1:  mem_addr = pc_r + 16'd1;
        RD_PTR:  mem_addr = {ptr_hi, ptr_lo};
        RD_PTR1: mem_addr = {ptr_hi, ptr_lo + 8'd1};
        default: mem_addr = pc_r;
      endcase
    end
  end

  assign base    = {b1_r, b0_r};
  assign npc_nxt = pc_r + {14'd0, op_bytes(mode_r)};

  always_comb begin
    case (mode_t'(mode_r))
      MODE_IMM:  ea_nxt = pc_r;
      MODE_ABS:  ea_nxt = base;
      MODE_ABSX: ea_nxt = base + {8'd0, x_r};
      MODE_ABSY: ea_nxt = base + {8'd0, y_r};
      MODE_ZP:   ea_nxt = {8'd0, b0_r};
      MODE_ZPX:  ea_nxt = {8'd0, b0_r + x_r};
      MODE_ZPY:  ea_nxt = {8'd0, b0_r + y_r};
      MODE_IND:  ea_nxt = {p1_r, p0_r};
      MODE_INDX: ea_nxt = {p1_r, p0_r};
      MODE_INDY: ea_nxt = {p1_r, p0_r} + {8'd0, y_r};
      MODE_REL:  ea_nxt = pc_r + 16'd1 + {{8{b0_r[7]}}, b0_r};
      default:   ea_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= in_data.mode;
      pc_r   <= in_data.prog_counter;
      x_r    <= in_data.x_index;
      y_r    <= in_data.y_index;
    end
    if (cmd.cap_b0) begin
      b0_r <= mem_rdata;
    end
    if (cmd.cap_b1) begin
      b1_r <= mem_rdata;
    end
    if (cmd.cap_p0) begin
      p0_r <= mem_rdata;
    end
    if (cmd.cap_p1) begin
      p1_r <= mem_rdata;
    end
    if (cmd.load_out) begin
      out_r.effective_address <= ea_nxt;
      out_r.next_pc           <= npc_nxt;
    end
  end

  assign status.mode = mode_r;
  assign out_data    = out_r;

endmodule

`default_nettype wire

@@ rtl/m6502am_chk.sv @@
`default_nettype none

module m6502am_chk (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire m6502am_pkg::in_item_t  in_data,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire m6502am_pkg::out_item_t out_data
);
  import m6502am_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a resolve beat makes the block busy
  a_resolve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_data.kind == KIND_RESOLVE |=> in_stall)
    else $error("input not stalled after resolve beat");

  // a write beat leaves the block ready
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_data.kind == KIND_WRITE |=> !in_stall)
    else $error("input stalled after write beat");

  // accumulator mode resolves to address zero
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_data.kind == KIND_RESOLVE && in_data.mode == MODE_ACC && !out_valid
    |-> ##2 out_valid && out_data.effective_address == 16'd0
        && out_data.next_pc == $past(in_data.prog_counter, 2))
    else $error("accumulator mode result wrong");

endmodule

bind mos6502_address_mode_unit m6502am_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
